### src/pipe_flow_and_waiter_control_core_defines.svh
// Assertion macros shared by the pipe control block.
`ifndef PIPE_FLOW_AND_WAITER_CONTROL_CORE_DEFINES_SVH
`define PIPE_FLOW_AND_WAITER_CONTROL_CORE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define PFWC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define PFWC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### src/pfwc_pkg.sv
package pfwc_pkg;

  // Default sizes of the pipe and of each waiter table.
  localparam int unsigned CAPACITY_DEF     = 512;
  localparam int unsigned WAITER_SLOTS_DEF = 8;

  // Request codes.
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TAKE  = 2'd2;
  localparam logic [1:0] CMD_GIVE  = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_AGAIN   = 3'd1;
  localparam logic [2:0] ST_BLOCKED = 3'd2;
  localparam logic [2:0] ST_BROKEN  = 3'd3;
  localparam logic [2:0] ST_EOS     = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;

  // One request beat.
  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  thread_id;
    logic [7:0]  thread_priority;
    logic [15:0] request_size;
    logic        nonblock;
    logic        end_is_writer;
  } pfwc_req_t;

  // One result beat.
  typedef struct packed {
    logic [2:0] status;
    logic [9:0] granted_bytes;
    logic       woken_valid;
    logic [7:0] woken_thread;
    logic       woken_was_writer;
    logic       released;
    logic       readable;
    logic       writable;
  } pfwc_rsp_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic eval;
    logic scan;
    logic remove;
    logic report;
  } pfwc_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic scan_last;
  } pfwc_sts_t;

endpackage

### src/pfwc_ctrl.sv
module pfwc_ctrl import pfwc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  pfwc_sts_t sts_i,
  output pfwc_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_REMOVE,
    S_REPORT
  } state_e;

  state_e state_q, state_d;

  // Next state of the request sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (start) state_d = S_EVAL;
      S_EVAL:   state_d = S_SCAN;
      S_SCAN:   if (sts_i.scan_last) state_d = S_REMOVE;
      S_REMOVE: state_d = S_REPORT;
      S_REPORT: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands decoded from the state.
  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == S_IDLE) && start;
    cmd_o.eval   = (state_q == S_EVAL);
    cmd_o.scan   = (state_q == S_SCAN);
    cmd_o.remove = (state_q == S_REMOVE);
    cmd_o.report = (state_q == S_REPORT);
  end

  assign busy = (state_q != S_IDLE);

endmodule

### src/pfwc_datapath.sv
`include "pipe_flow_and_waiter_control_core_defines.svh"

module pfwc_datapath import pfwc_pkg::*; #(
  parameter int unsigned CAPACITY     = CAPACITY_DEF,
  parameter int unsigned WAITER_SLOTS = WAITER_SLOTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  pfwc_req_t req_i,
  input  pfwc_cmd_t cmd_i,
  output pfwc_sts_t sts_o,
  output logic      result_valid_o,
  output pfwc_rsp_t rsp_o
);

  localparam int unsigned FW   = $clog2(CAPACITY + 1);
  localparam int unsigned CNTW = $clog2(WAITER_SLOTS + 1);
  localparam int unsigned IW   = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
  localparam logic [16:0] CAP  = 17'(CAPACITY);

  typedef struct packed {
    logic [7:0]  tid;
    logic [7:0]  prio;
    logic [15:0] size;
  } waiter_t;

  logic            stream_q;
  pfwc_req_t       req_q;
  logic [FW-1:0]   fill_q;
  logic [7:0]      rcnt_q, wcnt_q;
  logic            rd_flag_q, wr_flag_q;
  waiter_t         rd_tab_q [WAITER_SLOTS];
  waiter_t         wr_tab_q [WAITER_SLOTS];
  logic [CNTW-1:0] rd_cnt_q, wr_cnt_q;

  logic [2:0]      status_q;
  logic [9:0]      gnt_q;
  logic            wake_en_q, sel_wr_q, release_q;
  logic [16:0]     avail_q;
  logic [IW-1:0]   idx_q, best_q;
  logic            found_q;
  logic [7:0]      best_prio_q, best_tid_q;
  logic            valid_q;
  pfwc_rsp_t       rsp_q;

  // Decision of one request, taken from the captured beat and the counters.
  logic [16:0] fill17, size17, space17, take17, fill_new17;
  logic [2:0]  st_d;
  logic        go, enq_rd, enq_wr, wake_en_d, sel_wr_d, rel_d;
  logic [15:0] enq_size;
  logic [16:0] avail_d;
  logic [7:0]  rcnt_d, wcnt_d;

  always_comb begin
    fill17     = 17'(fill_q);
    size17     = 17'(req_q.request_size);
    space17    = CAP - fill17;
    take17     = size17;
    fill_new17 = fill17;
    st_d       = ST_DONE;
    go         = 1'b0;
    enq_rd     = 1'b0;
    enq_wr     = 1'b0;
    enq_size   = req_q.request_size;
    wake_en_d  = 1'b0;
    sel_wr_d   = 1'b0;
    avail_d    = '0;
    rcnt_d     = rcnt_q;
    wcnt_d     = wcnt_q;
    rel_d      = 1'b0;
    case (req_q.command)
      CMD_READ: begin
        if (stream_q && fill17 == '0 && wcnt_q == '0) begin
          st_d = ST_EOS;
        end else if (size17 > fill17) begin
          if (req_q.nonblock) begin
            if (fill17 != '0) begin
              take17 = fill17;
              go     = 1'b1;
            end else begin
              st_d = ST_AGAIN;
            end
          end else if (stream_q && fill17 != '0) begin
            take17 = fill17;
            go     = 1'b1;
          end else begin
            enq_rd   = 1'b1;
            enq_size = stream_q ? 16'd1 : req_q.request_size;
          end
        end else begin
          go = 1'b1;
        end
        if (go) begin
          fill_new17 = fill17 - take17;
          wake_en_d  = 1'b1;
          sel_wr_d   = 1'b1;
          avail_d    = CAP - fill_new17;
        end
      end
      CMD_WRITE: begin
        if (stream_q && rcnt_q == '0) begin
          st_d = ST_BROKEN;
        end else if (size17 > space17) begin
          if (req_q.nonblock) begin
            if (space17 != '0) begin
              take17 = space17;
              go     = 1'b1;
            end else begin
              st_d = ST_AGAIN;
            end
          end else begin
            enq_wr = 1'b1;
          end
        end else begin
          go = 1'b1;
        end
        if (go) begin
          fill_new17 = fill17 + take17;
          wake_en_d  = 1'b1;
          avail_d    = fill_new17;
        end
      end
      CMD_TAKE: begin
        if (req_q.end_is_writer) begin
          if (wcnt_q != 8'hFF) wcnt_d = wcnt_q + 8'd1;
        end else begin
          if (rcnt_q != 8'hFF) rcnt_d = rcnt_q + 8'd1;
        end
      end
      CMD_GIVE: begin
        if (req_q.end_is_writer) begin
          if (wcnt_q != '0) wcnt_d = wcnt_q - 8'd1;
          wake_en_d = (wcnt_d == '0);
        end else begin
          if (rcnt_q != '0) rcnt_d = rcnt_q - 8'd1;
          wake_en_d = (rcnt_d == '0);
          sel_wr_d  = 1'b1;
        end
        avail_d = CAP;
        rel_d   = (rcnt_d == '0) && (wcnt_d == '0);
      end
      default: ;
    endcase
    if (enq_rd) begin
      st_d = (rd_cnt_q < CNTW'(WAITER_SLOTS)) ? ST_BLOCKED : ST_FULL;
    end
    if (enq_wr) begin
      st_d = (wr_cnt_q < CNTW'(WAITER_SLOTS)) ? ST_BLOCKED : ST_FULL;
    end
  end

  // Entry under the scan pointer in the table being searched.
  waiter_t         scan_ent;
  logic [CNTW-1:0] scan_cnt;
  logic            scan_hit;

  always_comb begin
    scan_ent = sel_wr_q ? wr_tab_q[idx_q] : rd_tab_q[idx_q];
    scan_cnt = sel_wr_q ? wr_cnt_q : rd_cnt_q;
    scan_hit = wake_en_q && (CNTW'(idx_q) < scan_cnt) &&
               (17'(scan_ent.size) <= avail_q) &&
               (!found_q || (scan_ent.prio > best_prio_q));
  end

  assign sts_o.scan_last = (idx_q == IW'(WAITER_SLOTS - 1));

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_q <= 1'b0;
    end else if (cfg_we_i) begin
      stream_q <= cfg_wdata_i;
    end
  end

  // Captured request beat and per-request decision.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.eval) begin
      status_q  <= st_d;
      gnt_q     <= go ? take17[9:0] : 10'd0;
      wake_en_q <= wake_en_d;
      sel_wr_q  <= sel_wr_d;
      avail_q   <= avail_d;
      release_q <= rel_d;
    end
  end

  // Pipe counters, poll flags and table fill counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      rcnt_q    <= '0;
      wcnt_q    <= '0;
      rd_flag_q <= 1'b0;
      wr_flag_q <= 1'b0;
      rd_cnt_q  <= '0;
      wr_cnt_q  <= '0;
    end else if (cmd_i.eval) begin
      fill_q <= FW'(fill_new17);
      rcnt_q <= rcnt_d;
      wcnt_q <= wcnt_d;
      if (req_q.command == CMD_READ) rd_flag_q <= (fill_new17 != '0);
      if (req_q.command == CMD_WRITE) wr_flag_q <= (fill_new17 != CAP);
      if (enq_rd && st_d == ST_BLOCKED) rd_cnt_q <= rd_cnt_q + CNTW'(1);
      if (enq_wr && st_d == ST_BLOCKED) wr_cnt_q <= wr_cnt_q + CNTW'(1);
    end else if (cmd_i.remove && found_q) begin
      if (sel_wr_q) begin
        wr_cnt_q <= wr_cnt_q - CNTW'(1);
      end else begin
        rd_cnt_q <= rd_cnt_q - CNTW'(1);
      end
    end else if (cmd_i.report && release_q) begin
      fill_q    <= '0;
      rcnt_q    <= '0;
      wcnt_q    <= '0;
      rd_flag_q <= 1'b0;
      wr_flag_q <= 1'b0;
      rd_cnt_q  <= '0;
      wr_cnt_q  <= '0;
    end
  end

  // Waiter tables: append at the fill count, close the gap on removal.
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval && enq_rd && st_d == ST_BLOCKED) begin
      rd_tab_q[rd_cnt_q[IW-1:0]] <= '{req_q.thread_id, req_q.thread_priority, enq_size};
    end
    if (cmd_i.eval && enq_wr && st_d == ST_BLOCKED) begin
      wr_tab_q[wr_cnt_q[IW-1:0]] <= '{req_q.thread_id, req_q.thread_priority, enq_size};
    end
    if (cmd_i.remove && found_q) begin
      for (int i = 0; i < int'(WAITER_SLOTS) - 1; i++) begin
        if (i >= int'(best_q)) begin
          if (sel_wr_q) begin
            wr_tab_q[i] <= wr_tab_q[i + 1];
          end else begin
            rd_tab_q[i] <= rd_tab_q[i + 1];
          end
        end
      end
    end
  end

  // Priority scan, one table entry per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.eval) begin
      idx_q   <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.scan) begin
      if (!sts_o.scan_last) idx_q <= idx_q + IW'(1);
      if (scan_hit) found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && scan_hit) begin
      best_q      <= idx_q;
      best_prio_q <= scan_ent.prio;
      best_tid_q  <= scan_ent.tid;
    end
  end

  // Result beat, shown for one cycle after the report step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.report;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.report) begin
      rsp_q.status           <= status_q;
      rsp_q.granted_bytes    <= gnt_q;
      rsp_q.woken_valid      <= found_q;
      rsp_q.woken_thread     <= found_q ? best_tid_q : 8'd0;
      rsp_q.woken_was_writer <= found_q && sel_wr_q;
      rsp_q.released         <= release_q;
      rsp_q.readable         <= rd_flag_q && !release_q;
      rsp_q.writable         <= wr_flag_q && !release_q;
    end
  end

  assign result_valid_o = valid_q;
  assign rsp_o          = rsp_q;

  `PFWC_ASSERT(a_rd_cnt_bound, rd_cnt_q <= CNTW'(WAITER_SLOTS), "read waiter count overflow")
  `PFWC_ASSERT(a_fill_bound, 17'(fill_q) <= CAP, "fill level above capacity")
  `PFWC_ASSERT_NEVER(a_strobe_twice, valid_q && $past(valid_q), "result strobe held twice")

endmodule

### src/pipe_flow_and_waiter_control_core.sv
// Request controller of a bounded byte pipe. A request beat is taken when
// start is high and busy is low; its single result appears on rsp_o for one
// cycle, marked by result_valid_o, and cannot be held off by the receiver.
// Each request runs through a decision step, a search of the waiter table
// (eight slots by default) for the best wake candidate one entry per cycle,
// a removal step and a report step. The user must write stream_mode only
// while busy is low; the block itself does not enforce this.
module pipe_flow_and_waiter_control_core import pfwc_pkg::*; #(
  parameter int unsigned CAPACITY     = CAPACITY_DEF,
  parameter int unsigned WAITER_SLOTS = WAITER_SLOTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  logic      start,
  output logic      busy,
  input  pfwc_req_t req_i,
  output logic      result_valid_o,
  output pfwc_rsp_t rsp_o
);

  pfwc_cmd_t cmd;
  pfwc_sts_t sts;

  // Request sequencer.
  pfwc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Counters, waiter tables and result register.
  pfwc_datapath #(
    .CAPACITY     (CAPACITY),
    .WAITER_SLOTS (WAITER_SLOTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_i          (req_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

endmodule

### tb/pfwc_checker.sv
module pfwc_checker import pfwc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  logic      start,
  input  logic      busy,
  input  pfwc_req_t req_i,
  input  logic      result_valid_o,
  input  pfwc_rsp_t rsp_o,
  output int        fail_count,
  output int        pending_count,
  output int        result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP   = CAPACITY_DEF;
  localparam int SLOTS = WAITER_SLOTS_DEF;

  typedef struct {
    bit       valid;
    bit [7:0] tid;
    bit [7:0] prio;
    int       size;
  } waiter_entry_t;

  // Shadow copy of the pipe state.
  bit            stream_q;
  int            fill_q;
  int            readers_q;
  int            writers_q;
  waiter_entry_t rd_tab[SLOTS];
  waiter_entry_t wr_tab[SLOTS];
  bit            rd_flag_q;
  bit            wr_flag_q;

  pfwc_rsp_t expected_rsp_q[$];

  function automatic void clear_pipe();
    fill_q = 0;
    readers_q = 0;
    writers_q = 0;
    rd_flag_q = 0;
    wr_flag_q = 0;
    for (int i = 0; i < SLOTS; i++) begin
      rd_tab[i] = '{0, 0, 0, 0};
      wr_tab[i] = '{0, 0, 0, 0};
    end
  endfunction

  // Store a blocked request in the first free slot of a table.
  function automatic bit park_waiter(ref waiter_entry_t tab[SLOTS], input bit [7:0] tid,
                                     input bit [7:0] prio, input int size);
    for (int i = 0; i < SLOTS; i++) begin
      if (!tab[i].valid) begin
        tab[i] = '{1, tid, prio, size};
        return 1;
      end
    end
    return 0;
  endfunction

  // Pick the eligible waiter of highest priority, oldest first, and remove it.
  function automatic bit pop_best_waiter(ref waiter_entry_t tab[SLOTS], input int avail,
                                         output bit [7:0] tid);
    int best;
    best = -1;
    tid = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (tab[i].valid && tab[i].size <= avail &&
          (best < 0 || tab[i].prio > tab[best].prio)) best = i;
    end
    if (best < 0) return 0;
    tid = tab[best].tid;
    for (int i = best; i + 1 < SLOTS; i++) tab[i] = tab[i + 1];
    tab[SLOTS - 1] = '{0, 0, 0, 0};
    return 1;
  endfunction

  function automatic pfwc_rsp_t predict_pipe_result(pfwc_req_t rq);
    pfwc_rsp_t r;
    int        size;
    int        avail;
    bit        go;
    bit        woke;
    bit [7:0]  wtid;
    r = '0;
    size = int'(rq.request_size);
    woke = 0;
    wtid = 0;
    case (rq.command)
      CMD_READ: begin
        if (stream_q && fill_q == 0 && writers_q == 0) begin
          r.status = ST_EOS;
        end else begin
          go = 1;
          if (size > fill_q) begin
            if (rq.nonblock) begin
              if (fill_q > 0) size = fill_q;
              else begin
                r.status = ST_AGAIN;
                go = 0;
              end
            end else if (stream_q && fill_q > 0) begin
              size = fill_q;
            end else begin
              go = 0;
              r.status = park_waiter(rd_tab, rq.thread_id, rq.thread_priority,
                                     stream_q ? 1 : size) ? ST_BLOCKED : ST_FULL;
            end
          end
          if (go) begin
            fill_q -= size;
            r.granted_bytes = 10'(size);
            woke = pop_best_waiter(wr_tab, CAP - fill_q, wtid);
            r.woken_was_writer = woke;
          end
        end
        rd_flag_q = fill_q > 0;
      end
      CMD_WRITE: begin
        avail = CAP - fill_q;
        if (stream_q && readers_q == 0) begin
          r.status = ST_BROKEN;
        end else begin
          go = 1;
          if (size > avail) begin
            if (rq.nonblock) begin
              if (avail > 0) size = avail;
              else begin
                r.status = ST_AGAIN;
                go = 0;
              end
            end else begin
              go = 0;
              r.status = park_waiter(wr_tab, rq.thread_id, rq.thread_priority, size)
                         ? ST_BLOCKED : ST_FULL;
            end
          end
          if (go) begin
            fill_q += size;
            r.granted_bytes = 10'(size);
            woke = pop_best_waiter(rd_tab, fill_q, wtid);
          end
        end
        wr_flag_q = (CAP - fill_q) > 0;
      end
      CMD_TAKE: begin
        if (rq.end_is_writer) begin
          if (writers_q < 255) writers_q++;
        end else if (readers_q < 255) begin
          readers_q++;
        end
      end
      default: begin
        if (rq.end_is_writer) begin
          if (writers_q > 0) writers_q--;
          if (writers_q == 0) woke = pop_best_waiter(rd_tab, CAP, wtid);
        end else begin
          if (readers_q > 0) readers_q--;
          if (readers_q == 0) begin
            woke = pop_best_waiter(wr_tab, CAP, wtid);
            r.woken_was_writer = woke;
          end
        end
        if (readers_q == 0 && writers_q == 0) begin
          clear_pipe();
          r.released = 1;
        end
      end
    endcase
    r.woken_valid = woke;
    r.woken_thread = wtid;
    r.readable = rd_flag_q;
    r.writable = wr_flag_q;
    return r;
  endfunction

  // Track configuration, predict on each accepted request, compare each result.
  always @(posedge clk_i or negedge rst_ni) begin
    pfwc_rsp_t exp_rsp;
    if (!rst_ni) begin
      stream_q = 0;
      clear_pipe();
      expected_rsp_q.delete();
      fail_count = 0;
      result_count = 0;
      pending_count = 0;
    end else begin
      if (result_valid_o) begin
        result_count++;
        if (expected_rsp_q.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected, actual %p", $time, rsp_o);
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (rsp_o !== exp_rsp) begin
            fail_count++;
            $display("%0t: result mismatch, expected %p, actual %p", $time, exp_rsp, rsp_o);
          end
        end
      end
      if (cfg_we_i) stream_q = cfg_wdata_i;
      if (start && !busy) expected_rsp_q.push_back(predict_pipe_result(req_i));
      pending_count = expected_rsp_q.size();
    end
  end
endmodule

### tb/tb_pipe_flow_and_waiter_control_core.sv
module tb_pipe_flow_and_waiter_control_core;
  import pfwc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;

  logic      clk_i = 0;
  logic      rst_ni = 0;
  logic      cfg_we_i = 0;
  logic      cfg_wdata_i = 0;
  logic      start = 0;
  logic      busy;
  pfwc_req_t req_i = '0;
  logic      result_valid_o;
  pfwc_rsp_t rsp_o;
  int        fail_count;
  int        pending_count;
  int        result_count;
  int        idle_cycles = 0;
  int        beats_sent = 0;

  pipe_flow_and_waiter_control_core uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .start, .busy,
    .req_i, .result_valid_o, .rsp_o
  );

  pfwc_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .start, .busy, .req_i,
    .result_valid_o, .rsp_o, .fail_count, .pending_count, .result_count
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on cycles without any accepted beat or result beat.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Present one request beat after a random gap and hold it until taken.
  // The gap always covers at least one falling edge, so start is never
  // lowered and raised again in the same time step.
  task automatic send_request(logic [1:0] cmd, logic [7:0] tid, logic [7:0] prio,
                              logic [15:0] size, logic nb, logic wr, bit gaps = 1);
    int gap;
    gap = gaps ? $urandom_range(0, 16) : 0;
    repeat (gap + 1) @(negedge clk_i);
    req_i <= '{command: cmd, thread_id: tid, thread_priority: prio,
               request_size: size, nonblock: nb, end_is_writer: wr};
    start <= 1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    start <= 0;
    beats_sent++;
  endtask

  task automatic drain_results();
    while (pending_count != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_stream_mode(logic v);
    drain_results();
    cfg_wdata_i <= v;
    cfg_we_i <= 1;
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  // Random size: mostly small, sometimes near or past the capacity.
  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 65535);
      1: return $urandom_range(500, 600);
      2: return 0;
      default: return $urandom_range(1, 200);
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [1:0] cmd;
    bit         gaps;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) gaps = $urandom_range(0, 2) != 0;
      case ($urandom_range(0, 19))
        0, 1:       cmd = CMD_TAKE;
        2:          cmd = CMD_GIVE;
        3, 4, 5, 6, 7, 8, 9, 10: cmd = CMD_READ;
        default:    cmd = CMD_WRITE;
      endcase
      send_request(cmd, $urandom_range(0, 255), $urandom_range(0, 7) == 0 ?
                   $urandom_range(0, 255) : $urandom_range(0, 3), pick_size(),
                   $urandom_range(0, 1), $urandom_range(0, 1), gaps);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed: message mode, counts, blocking, full table, wakes, release.
    send_request(CMD_TAKE, 0, 0, 0, 0, 0);
    send_request(CMD_TAKE, 0, 0, 0, 0, 1);
    send_request(CMD_READ, 8'hFF, 8'hFF, 16'hFFFF, 1, 0);
    for (int i = 0; i < 9; i++) send_request(CMD_READ, i, i % 3, 16'd10, 0, 0);
    send_request(CMD_WRITE, 8'hAA, 0, 16'd512, 0, 1);
    send_request(CMD_WRITE, 8'h55, 8'h80, 16'hFFFF, 0, 0);
    send_request(CMD_WRITE, 1, 1, 16'd5, 1, 0);
    send_request(CMD_READ, 2, 2, 16'd0, 0, 1);
    send_request(CMD_GIVE, 0, 0, 0, 0, 0);
    send_request(CMD_GIVE, 0, 0, 0, 0, 1);
    send_request(CMD_GIVE, 0, 0, 0, 0, 1);

    // Directed: stream mode end of stream, broken pipe, short reads.
    write_stream_mode(1);
    send_request(CMD_READ, 3, 3, 16'd4, 0, 0);
    send_request(CMD_WRITE, 4, 4, 16'd4, 0, 0);
    send_request(CMD_TAKE, 0, 0, 0, 0, 0);
    send_request(CMD_TAKE, 0, 0, 0, 0, 1);
    send_request(CMD_WRITE, 5, 5, 16'd100, 0, 1);
    send_request(CMD_READ, 6, 6, 16'd300, 0, 0);
    send_request(CMD_READ, 7, 7, 16'd8, 0, 0);
    send_request(CMD_WRITE, 8, 8, 16'd50, 0, 0);
    send_request(CMD_GIVE, 0, 0, 0, 0, 1);

    // Saturate the reader count, then random traffic in both modes.
    write_stream_mode(0);
    for (int i = 0; i < 257; i++) send_request(CMD_TAKE, 0, 0, 0, 0, 0, 0);
    send_request(CMD_TAKE, 0, 0, 0, 0, 1);
    random_phase(500);
    write_stream_mode(1);
    random_phase(500);
    write_stream_mode(0);
    random_phase(250);
    write_stream_mode(1);
    random_phase(250);

    drain_results();
    $display("Sent %0d requests and checked %0d results in message and stream modes,",
             beats_sent, result_count);
    $display("covering blocking, wakes, full tables, count limits and release.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
